@@ src/tcf_pkg.sv @@
package tcf_pkg;

  // cordic iteration count, table size, square root step count and counter width
  localparam int CordicSteps = 16;
  localparam int AtanCount   = 24;
  localparam int SqrtSteps   = 16;
  localparam int CntW        = 5;

  // register indexes of the configuration port
  typedef enum logic [2:0] {
    REG_ROLL_MODE       = 3'd0,
    REG_GYRO_SCALE      = 3'd1,
    REG_GYRO_OFFSET     = 3'd2,
    REG_SAMPLE_PERIOD   = 3'd3,
    REG_RATE_CENTRE     = 3'd4,
    REG_GYRO_DEVIATION  = 3'd5,
    REG_ACCEL_OFFSET    = 3'd6,
    REG_ACCEL_DEVIATION = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [15:0] gyro_raw;
    logic [15:0] accel_x_raw;
    logic [15:0] accel_y_raw;
    logic [15:0] accel_z_raw;
  } in_item_t;

  typedef struct packed {
    logic [23:0] fused_angle;
    logic [16:0] accel_angle;
  } out_item_t;

  typedef struct packed {
    logic        roll_mode;
    logic [15:0] gyro_scale;
    logic [23:0] gyro_offset;
    logic [15:0] sample_period;
    logic [23:0] rate_centre;
    logic [22:0] gyro_deviation;
    logic [16:0] accel_offset;
    logic [15:0] accel_deviation;
  } cfg_t;

  // handshake between queue and engine
  typedef struct packed {
    logic valid;
    logic pop;
  } q_ctrl_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RATE, S_INC, S_INT, S_SQ1, S_SQ2, S_SQRT, S_CINIT,
    S_CORD, S_ACC, S_PULL1, S_PULL2, S_BL1, S_BL2, S_DONE
  } state_e;

  // saturate a wide signed value to 24 bits
  function automatic logic signed [23:0] sat24(input logic signed [47:0] v);
    logic signed [23:0] r;
    if (v > 48'sd8388607) r = 24'sh7FFFFF;
    else if (v < -48'sd8388608) r = 24'sh800000;
    else r = v[23:0];
    return r;
  endfunction

  // arctangent of 2^-i in degrees, 16 fraction bits
  function automatic logic [21:0] atan_lut(input logic [CntW-1:0] i);
    logic [21:0] r;
    case (i)
      5'd0:  r = 22'd2949120;
      5'd1:  r = 22'd1740967;
      5'd2:  r = 22'd919879;
      5'd3:  r = 22'd466945;
      5'd4:  r = 22'd234379;
      5'd5:  r = 22'd117304;
      5'd6:  r = 22'd58666;
      5'd7:  r = 22'd29335;
      5'd8:  r = 22'd14668;
      5'd9:  r = 22'd7334;
      5'd10: r = 22'd3667;
      5'd11: r = 22'd1833;
      5'd12: r = 22'd917;
      5'd13: r = 22'd458;
      5'd14: r = 22'd229;
      5'd15: r = 22'd115;
      5'd16: r = 22'd57;
      5'd17: r = 22'd29;
      5'd18: r = 22'd14;
      5'd19: r = 22'd7;
      5'd20: r = 22'd4;
      5'd21: r = 22'd2;
      5'd22: r = 22'd1;
      default: r = 22'd0;
    endcase
    return r;
  endfunction

endpackage

@@ src/tcf_front.sv @@
module tcf_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  tcf_pkg::in_item_t in_data_i,
  input  tcf_pkg::q_ctrl_t  q_ctrl_i,
  output logic              q_valid_o,
  output tcf_pkg::in_item_t q_item_o
);
  import tcf_pkg::*;

  in_item_t   mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push, pop;

  // two-entry queue in front of the engine
  assign in_stall_o = (count_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = q_ctrl_i.pop && (count_q != 2'd0);
  assign q_valid_o  = (count_q != 2'd0);
  assign q_item_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= in_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + 2'(push) - 2'(pop);
    end
  end

endmodule

@@ src/tcf_back.sv @@
module tcf_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tcf_pkg::cfg_t      cfg_i,
  input  logic               q_valid_i,
  input  tcf_pkg::in_item_t  q_item_i,
  output tcf_pkg::q_ctrl_t   q_ctrl_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output tcf_pkg::out_item_t out_data_o
);
  import tcf_pkg::*;

  state_e state_q, state_d;
  in_item_t item_q, item_d;
  logic signed [23:0] rate_q, rate_d, inc_q, inc_d, a_q, a_d, est_q, est_d;
  logic [31:0] sq_q, sq_d, v_q, v_d, r_q, r_d, bit_q, bit_d;
  logic signed [16:0] num_q, num_d, acc_q, acc_d;
  logic signed [39:0] x_q, x_d, y_q, y_d;
  logic signed [26:0] z_q, z_d;
  logic signed [47:0] prod_q, prod_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  out_item_t out_q, out_d;
  logic out_valid_q, out_valid_d;
  logic load, pop, num_zero, pull_out;
  logic signed [47:0] wa, wacc, cband;

  // correction band test on the working angle
  always_comb begin
    wa       = a_q;
    wacc     = acc_q;
    cband    = $signed({32'd0, cfg_i.accel_deviation}) * 48'sd5;
    pull_out = !((wa < wacc + cband) && (wa > wacc - cband));
  end
  assign num_zero = (num_q == 17'sd0);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (q_valid_i) state_d = S_RATE;
      S_RATE:  state_d = S_INC;
      S_INC:   state_d = S_INT;
      S_INT:   state_d = S_SQ1;
      S_SQ1:   state_d = S_SQ2;
      S_SQ2:   state_d = S_SQRT;
      S_SQRT:  if (cnt_q == CntW'(SqrtSteps - 1)) state_d = S_CINIT;
      S_CINIT: state_d = num_zero ? S_ACC : S_CORD;
      S_CORD:  if (cnt_q == CntW'(CordicSteps - 1)) state_d = S_ACC;
      S_ACC:   state_d = S_PULL1;
      S_PULL1: state_d = pull_out ? S_PULL2 : S_BL1;
      S_PULL2: state_d = S_BL1;
      S_BL1:   state_d = S_BL2;
      S_BL2:   state_d = S_DONE;
      S_DONE:  if (load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    pop  = (state_q == S_IDLE) && q_valid_i;
    load = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);
  end
  assign q_ctrl_o.pop   = pop;
  assign q_ctrl_o.valid = q_valid_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_q;

  // datapath
  always_comb begin
    logic signed [47:0] p, t, u, mean, band;
    logic signed [16:0] n;
    logic [31:0] trial;
    logic signed [39:0] xs, ys;
    item_d = item_q; rate_d = rate_q; inc_d = inc_q; a_d = a_q; est_d = est_q;
    sq_d = sq_q; v_d = v_q; r_d = r_q; bit_d = bit_q; num_d = num_q; acc_d = acc_q;
    x_d = x_q; y_d = y_q; z_d = z_q; prod_d = prod_q; cnt_d = cnt_q; out_d = out_q;
    p = '0; t = '0; u = '0; mean = '0; band = '0; n = '0; trial = '0; xs = '0; ys = '0;
    case (state_q)
      S_IDLE: if (pop) item_d = q_item_i;
      S_RATE: begin
        p      = $signed(item_q.gyro_raw) * $signed({1'b0, cfg_i.gyro_scale});
        t      = sat24((p + 48'sd128) >>> 8);
        u      = $signed(cfg_i.gyro_offset);
        rate_d = sat24(t - u);
      end
      S_INC: begin
        p     = rate_q * $signed({1'b0, cfg_i.sample_period});
        t     = (p + 48'sd32768) >>> 16;
        inc_d = t[23:0];
      end
      S_INT: begin
        // dead band around the gyro mean, strict on both sides
        mean = $signed(cfg_i.rate_centre);
        band = $signed({25'd0, cfg_i.gyro_deviation}) * 48'sd30;
        t    = rate_q;
        u    = est_q;
        p    = inc_q;
        if (!((t < mean + band) && (t > mean - band))) a_d = sat24(u + p);
        else a_d = est_q;
      end
      S_SQ1: begin
        n     = cfg_i.roll_mode ? $signed(item_q.accel_x_raw) : $signed(item_q.accel_y_raw);
        p     = n * n;
        sq_d  = p[31:0];
        n     = cfg_i.roll_mode ? $signed(item_q.accel_y_raw) : -$signed(item_q.accel_x_raw);
        num_d = n;
      end
      S_SQ2: begin
        n     = $signed(item_q.accel_z_raw);
        p     = n * n;
        v_d   = sq_q + p[31:0];
        r_d   = '0;
        bit_d = 32'h4000_0000;
        cnt_d = '0;
      end
      S_SQRT: begin
        // one result bit per step
        trial = r_q + bit_q;
        if (v_q >= trial) begin
          v_d = v_q - trial;
          r_d = (r_q >> 1) + bit_q;
        end else begin
          r_d = r_q >> 1;
        end
        bit_d = bit_q >> 2;
        cnt_d = cnt_q + 1'b1;
      end
      S_CINIT: begin
        x_d   = $signed({8'd0, r_q[15:0], 16'd0});
        y_d   = {{7{num_q[16]}}, num_q, 16'd0};
        z_d   = '0;
        cnt_d = '0;
      end
      S_CORD: begin
        xs = x_q >>> cnt_q;
        ys = y_q >>> cnt_q;
        if (!y_q[39]) begin
          x_d = x_q + ys;
          y_d = y_q - xs;
          z_d = z_q + $signed({5'd0, atan_lut(cnt_q)});
        end else begin
          x_d = x_q - ys;
          y_d = y_q + xs;
          z_d = z_q - $signed({5'd0, atan_lut(cnt_q)});
        end
        cnt_d = cnt_q + 1'b1;
      end
      S_ACC: begin
        t = z_q;
        t = (t + 48'sd128) >>> 8;
        u = $signed(cfg_i.accel_offset);
        t = t - u;
        if (t > 48'sd46080) t = 48'sd46080;
        else if (t < -48'sd46080) t = -48'sd46080;
        acc_d = t[16:0];
      end
      S_PULL1: prod_d = wa * 48'sd58982 + 48'sd32768;
      S_PULL2: a_d = sat24((prod_q + wacc * 48'sd6554) >>> 16);
      S_BL1:   prod_d = wa * 48'sd64881 + 48'sd32768;
      S_BL2:   a_d = sat24((prod_q + wacc * 48'sd655) >>> 16);
      S_DONE: begin
        if (load) begin
          est_d             = a_q;
          out_d.fused_angle = a_q;
          out_d.accel_angle = acc_q;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (load) out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d; rate_q <= rate_d; inc_q <= inc_d; a_q <= a_d;
    sq_q <= sq_d; v_q <= v_d; r_q <= r_d; bit_q <= bit_d; num_q <= num_d;
    acc_q <= acc_d; x_q <= x_d; y_q <= y_d; z_q <= z_d; prod_q <= prod_d;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      est_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      est_q       <= est_d;
      out_valid_q <= out_valid_d;
    end
  end

  // items leave the queue only when the engine is free
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> (state_q == S_IDLE))
    else $error("pop outside idle");

  // a finished result waits while the output is blocked
  a_done_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && !load) |=> (state_q == S_DONE))
    else $error("result lost");

  // cordic counter stays inside the table
  a_cord_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CORD) |-> (cnt_q < CntW'(CordicSteps)))
    else $error("cordic count overrun");

  // a load always raises the output valid
  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> out_valid_q)
    else $error("load without valid");

endmodule

@@ src/tilt_complementary_filter.sv @@
// Tilt complementary filter: one gyro axis and a three-axis accelerometer give a fused
// roll or pitch angle in degrees with 8 fraction bits (saturated to 24 bits), plus the
// accelerometer angle alone. Items enter a two-entry queue and are processed one at a
// time by a sequencer; an extra pull step runs when the kept angle is pulled toward the
// accelerometer angle, and the CORDIC steps are skipped when the arctangent numerator is
// zero. The time is set by the 16-step square root and the CORDIC arctangent, which
// share one step counter. The result sits in an output register, so the next item can
// be taken meanwhile. Configuration is written through the cfg channel, always ready;
// the user must write it only while idle, which the block itself does not enforce.
module tilt_complementary_filter (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  tcf_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output tcf_pkg::out_item_t out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [23:0]        cfg_data_i
);
  import tcf_pkg::*;

  cfg_t      cfg_q;
  logic      q_valid;
  in_item_t  q_item;
  q_ctrl_t   q_ctrl;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.roll_mode       <= 1'b1;
      cfg_q.gyro_scale      <= 16'd500;
      cfg_q.gyro_offset     <= '0;
      cfg_q.sample_period   <= 16'd655;
      cfg_q.rate_centre     <= '0;
      cfg_q.gyro_deviation  <= '0;
      cfg_q.accel_offset    <= '0;
      cfg_q.accel_deviation <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_ROLL_MODE:       cfg_q.roll_mode       <= cfg_data_i[0];
        REG_GYRO_SCALE:      cfg_q.gyro_scale      <= cfg_data_i[15:0];
        REG_GYRO_OFFSET:     cfg_q.gyro_offset     <= cfg_data_i;
        REG_SAMPLE_PERIOD:   cfg_q.sample_period   <= cfg_data_i[15:0];
        REG_RATE_CENTRE:     cfg_q.rate_centre     <= cfg_data_i;
        REG_GYRO_DEVIATION:  cfg_q.gyro_deviation  <= cfg_data_i[22:0];
        REG_ACCEL_OFFSET:    cfg_q.accel_offset    <= cfg_data_i[16:0];
        REG_ACCEL_DEVIATION: cfg_q.accel_deviation <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // input queue
  tcf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_ctrl_i   (q_ctrl),
    .q_valid_o  (q_valid),
    .q_item_o   (q_item)
  );

  // filter engine
  tcf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_ctrl_o    (q_ctrl),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
